### hw/rtl/min_queue_two_stacks_top_defines.svh
// Assertion macros for the min queue checker.
`ifndef MIN_QUEUE_TWO_STACKS_TOP_DEFINES_SVH
`define MIN_QUEUE_TWO_STACKS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MQTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("min queue check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MQTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("min queue check failed");

`endif

### hw/rtl/mqts_pkg.sv
// Shared types and constants of the min queue.
`timescale 1ns / 1ps
package mqts_pkg;

   localparam int DATA_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_FRONT   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_MIN     = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SIZE    = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_VALUE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

   // One stack entry: the value and the running minimum at and below it.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] minimum;
   } stack_entry_type;

   // Port strobes of one stack memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } stack_ctl_type;

endpackage

### hw/rtl/min_queue_two_stacks_top.sv
// Top level of the min queue: two-stack FIFO with running minimum.
//
//  channel  | ports                                   | transfer when
//  ---------+-----------------------------------------+--------------------
//  request  | req_opcode, req_push_value              | start & !busy
//  response | rsp_status, rsp_result_value,           | rsp_valid (1 cycle)
//           | rsp_element_count                       |
//
// Size, clear, errors and enqueue on an empty in-stack answer straight from the
// decode state; other commands first do one registered memory read. A
// dequeue that finds the out-stack empty first moves the in-stack element by
// element (read in-stack, then write out-stack), so the count of moved
// elements sets that command's length.
// Reset clears both depths and the sequencer; memory contents are left as is.
// The receiver cannot stall: each response shows for exactly one cycle.
`timescale 1ns / 1ps
module min_queue_two_stacks_top #(
   parameter int CAPACITY = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mqts_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [mqts_pkg::DATA_W-1:0]   req_push_value,
   output logic                                 rsp_valid,
   output logic [mqts_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [mqts_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [mqts_pkg::COUNT_W-1:0]         rsp_element_count
);
   import mqts_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int DW = $clog2(CAPACITY + 1);
   localparam int SW = (DW + 1 > COUNT_W) ? DW + 1 : COUNT_W;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ENQ    = 3'd2;
   localparam logic [2:0] S_XRD    = 3'd3;
   localparam logic [2:0] S_XWR    = 3'd4;
   localparam logic [2:0] S_POP    = 3'd5;
   localparam logic [2:0] S_FRONT  = 3'd6;
   localparam logic [2:0] S_MIN    = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [DW-1:0]       in_depth_ff, in_depth_in;
   logic [DW-1:0]       out_depth_ff, out_depth_in;
   logic [DATA_W-1:0]   xfer_min_ff, xfer_min_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   stack_ctl_type       in_ctl, out_ctl;
   logic [AW-1:0]       in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
   stack_entry_type     in_wr_data, out_wr_data, in_rd_data, out_rd_data;

   logic [DATA_W-1:0]   unit_a, unit_b, unit_min;

   logic [SW-1:0]       total_now, total_next;
   logic                accept, empty, full;
   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic [DATA_W-1:0]   emit_value;
   logic [AW-1:0]       in_top_addr, out_top_addr;

   assign accept       = start && !busy;
   assign busy         = (state_ff != S_IDLE);
   assign total_now    = SW'(in_depth_ff) + SW'(out_depth_ff);
   assign empty        = (total_now == '0);
   assign full         = (total_now >= SW'(CAPACITY));
   assign in_top_addr  = in_depth_ff[AW-1:0] - AW'(1);
   assign out_top_addr = out_depth_ff[AW-1:0] - AW'(1);

   mqts_stack #(.DEPTH(CAPACITY), .ADDR_W(AW)) u_in_stack (
      .clock   (clock),
      .ctl     (in_ctl),
      .wr_addr (in_wr_addr),
      .wr_data (in_wr_data),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   mqts_stack #(.DEPTH(CAPACITY), .ADDR_W(AW)) u_out_stack (
      .clock   (clock),
      .ctl     (out_ctl),
      .wr_addr (out_wr_addr),
      .wr_data (out_wr_data),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   // the one compare unit, shared by enqueue, move and min
   mqts_min_unit u_min (
      .a       (unit_a),
      .b       (unit_b),
      .minimum (unit_min)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      in_depth_in  = in_depth_ff;
      out_depth_in = out_depth_ff;
      xfer_min_in  = xfer_min_ff;

      in_ctl       = '0;
      out_ctl      = '0;
      in_wr_addr   = in_depth_ff[AW-1:0];
      out_wr_addr  = out_depth_ff[AW-1:0];
      in_rd_addr   = in_top_addr;
      out_rd_addr  = out_top_addr;
      in_wr_data   = '{value: val_ff, minimum: val_ff};
      out_wr_data  = '{value: in_rd_data.value, minimum: in_rd_data.value};

      unit_a       = val_ff;
      unit_b       = in_rd_data.minimum;

      emit         = 1'b0;
      emit_status  = ST_OK;
      emit_value   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               val_in   = req_push_value;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_ENQUEUE: begin
                  if (full) begin
                     emit        = 1'b1;
                     emit_status = ST_ERROR;
                     state_in    = S_IDLE;
                  end else if (in_depth_ff == '0) begin
                     // first in-stack entry: its own minimum
                     in_ctl.wr_en = 1'b1;
                     in_depth_in  = in_depth_ff + DW'(1);
                     emit         = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     in_ctl.rd_en = 1'b1;
                     state_in     = S_ENQ;
                  end
               end
               OP_DEQUEUE: begin
                  if (empty) begin
                     emit        = 1'b1;
                     emit_status = ST_ERROR;
                     state_in    = S_IDLE;
                  end else if (out_depth_ff == '0) begin
                     state_in = S_XRD;
                  end else begin
                     out_ctl.rd_en = 1'b1;
                     state_in      = S_POP;
                  end
               end
               OP_FRONT: begin
                  if (empty) begin
                     emit        = 1'b1;
                     emit_status = ST_ERROR;
                     state_in    = S_IDLE;
                  end else begin
                     // out-stack empty: the oldest is the in-stack bottom
                     in_rd_addr    = '0;
                     in_ctl.rd_en  = (out_depth_ff == '0);
                     out_ctl.rd_en = (out_depth_ff != '0);
                     state_in      = S_FRONT;
                  end
               end
               OP_MIN: begin
                  if (empty) begin
                     emit        = 1'b1;
                     emit_status = ST_ERROR;
                     state_in    = S_IDLE;
                  end else begin
                     in_ctl.rd_en  = (in_depth_ff != '0);
                     out_ctl.rd_en = (out_depth_ff != '0);
                     state_in      = S_MIN;
                  end
               end
               OP_SIZE: begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end
               OP_CLEAR: begin
                  in_depth_in  = '0;
                  out_depth_in = '0;
                  emit         = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  emit        = 1'b1;
                  emit_status = ST_ERROR;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_ENQ: begin
            in_wr_data   = '{value: val_ff, minimum: unit_min};
            in_ctl.wr_en = 1'b1;
            in_depth_in  = in_depth_ff + DW'(1);
            emit         = 1'b1;
            state_in     = S_IDLE;
         end
         S_XRD: begin
            in_ctl.rd_en = 1'b1;
            state_in     = S_XWR;
         end
         S_XWR: begin
            unit_a = in_rd_data.value;
            unit_b = xfer_min_ff;
            if (out_depth_ff != '0) begin
               out_wr_data.minimum = unit_min;
            end
            out_ctl.wr_en = 1'b1;
            xfer_min_in   = out_wr_data.minimum;
            in_depth_in   = in_depth_ff - DW'(1);
            out_depth_in  = out_depth_ff + DW'(1);
            // last element moved: rerun the dequeue on a loaded out-stack
            state_in      = (in_depth_ff == DW'(1)) ? S_DECODE : S_XRD;
         end
         S_POP: begin
            out_depth_in = out_depth_ff - DW'(1);
            emit         = 1'b1;
            emit_status  = ST_VALUE;
            emit_value   = out_rd_data.value;
            state_in     = S_IDLE;
         end
         S_FRONT: begin
            emit        = 1'b1;
            emit_status = ST_VALUE;
            emit_value  = (out_depth_ff == '0) ? in_rd_data.value : out_rd_data.value;
            state_in    = S_IDLE;
         end
         S_MIN: begin
            unit_a      = out_rd_data.minimum;
            unit_b      = in_rd_data.minimum;
            emit        = 1'b1;
            emit_status = ST_VALUE;
            if (in_depth_ff == '0) begin
               emit_value = out_rd_data.minimum;
            end else if (out_depth_ff == '0) begin
               emit_value = in_rd_data.minimum;
            end else begin
               emit_value = unit_min;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response carries the count after the command, kept to 11 bits
   assign total_next     = SW'(in_depth_in) + SW'(out_depth_in);
   assign rsp_valid_in   = emit;
   assign rsp_status_in  = emit_status;
   assign rsp_value_in   = emit_value;
   assign rsp_count_in   = total_next[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_depth_ff  <= '0;
         out_depth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_depth_ff  <= in_depth_in;
         out_depth_ff <= out_depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      xfer_min_ff <= xfer_min_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

### hw/rtl/mqts_min_unit.sv
// Shared signed minimum compare.
`timescale 1ns / 1ps
module mqts_min_unit (
   input  logic [mqts_pkg::DATA_W-1:0] a,
   input  logic [mqts_pkg::DATA_W-1:0] b,
   output logic [mqts_pkg::DATA_W-1:0] minimum
);
   import mqts_pkg::*;

   assign minimum = ($signed(a) < $signed(b)) ? a : b;

endmodule

### hw/rtl/mqts_stack.sv
// Stack storage: one write port, one registered read port.
`timescale 1ns / 1ps
module mqts_stack #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  mqts_pkg::stack_ctl_type   ctl,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  mqts_pkg::stack_entry_type wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output mqts_pkg::stack_entry_type rd_data
);
   import mqts_pkg::*;

   stack_entry_type mem [DEPTH];
   stack_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mqts_checker.sv
// Port-level checker for the min queue, bound to the top level.
`timescale 1ns / 1ps
`include "min_queue_two_stacks_top_defines.svh"
module mqts_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [mqts_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [mqts_pkg::DATA_W-1:0]  rsp_result_value
);
   import mqts_pkg::*;

   `MQTS_ASSERT_NOW(a_status_legal, rsp_valid, rsp_status <= ST_ERROR)
   `MQTS_ASSERT_NOW(a_value_zero, rsp_valid && rsp_status != ST_VALUE, rsp_result_value == '0)
   `MQTS_ASSERT_NOW(a_idle_on_rsp, rsp_valid, !busy)
   `MQTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `MQTS_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)

endmodule

bind min_queue_two_stacks_top mqts_checker u_mqts_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_result_value (rsp_result_value)
);

### test/tb_top.sv
// Self-checking testbench for the two-stack min queue (min_queue_two_stacks_top).
`timescale 1ns / 1ps
module tb_top;
   import mqts_pkg::*;

   // Queue depth of the instance; the predictor enforces the same bound.
   localparam int DEPTH = 1024;

   // Cycles with no transfer in either direction before the run is declared hung.
   // The worst legal case is a dequeue that moves a full in-stack, with sender
   // gaps on top of that.
   localparam int STALL_LIMIT = 20000;

   // Quiet cycles after the last expected response, to catch stray strobes.
   localparam int DRAIN_CYCLES = 16;

   localparam int RANDOM_ITEMS = 900;

   // Opcodes that the block does not decode; both must answer with an error.
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic [COUNT_W-1:0]       count;
   } response_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [OPCODE_W-1:0]        req_opcode;
   logic signed [DATA_W-1:0]   req_push_value;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_result_value;
   logic [COUNT_W-1:0]         rsp_element_count;

   // Predictor state: the queue contents, oldest first. The block's two stacks
   // are an implementation detail; from outside it is a FIFO with a minimum.
   logic signed [DATA_W-1:0]   held_values[$];

   // Responses predicted at request transfer, waiting for the strobe.
   response_type               pending_responses[$];

   int unsigned                mismatch_count = 0;
   int unsigned                stall_cycles = 0;

   // When set, the sender inserts random gaps between requests.
   bit                         idle_enable = 1'b1;

   min_queue_two_stacks_top #(
      .CAPACITY(DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_element_count(rsp_element_count)
   );

   // 2 ns period: one delay high, one low.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Signed minimum over everything held; only called when not empty.
   function automatic logic signed [DATA_W-1:0] smallest_held();
      logic signed [DATA_W-1:0] lowest;
      lowest = held_values[0];
      foreach (held_values[i])
         if (held_values[i] < lowest) lowest = held_values[i];
      return lowest;
   endfunction

   // Applies one transferred command to the predictor and queues its response.
   // Errors (empty, full, unused opcode) leave the contents untouched.
   function automatic void predict_response(input logic [OPCODE_W-1:0] op,
                                            input logic signed [DATA_W-1:0] val);
      response_type want;
      want.status = ST_ERROR;
      want.value  = '0;
      case (op)
         OP_ENQUEUE: begin
            if (held_values.size() < DEPTH) begin
               held_values.push_back(val);
               want.status = ST_OK;
            end
         end
         OP_DEQUEUE: begin
            if (held_values.size() != 0) begin
               want.value  = held_values.pop_front();
               want.status = ST_VALUE;
            end
         end
         OP_FRONT: begin
            // With an empty out-stack this is the bottom of the in-stack,
            // which is still the oldest element.
            if (held_values.size() != 0) begin
               want.value  = held_values[0];
               want.status = ST_VALUE;
            end
         end
         OP_MIN: begin
            if (held_values.size() != 0) begin
               want.value  = smallest_held();
               want.status = ST_VALUE;
            end
         end
         OP_SIZE: begin
            want.status = ST_OK;
         end
         OP_CLEAR: begin
            held_values.delete();
            want.status = ST_OK;
         end
         default: ;
      endcase
      want.count = COUNT_W'(held_values.size());
      pending_responses.push_back(want);
   endfunction

   // Drives one request and returns on the falling edge after its transfer.
   // Start stays high on return so back-to-back requests need no gap.
   task automatic send_command(input logic [OPCODE_W-1:0] op,
                               input logic signed [DATA_W-1:0] val);
      while (idle_enable && $urandom_range(99) < 30) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_opcode     = op;
      req_push_value = val;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_response(op, val);
      @(negedge clock);
   endtask

   // Full-range random words for half the picks, with the extremes, zero and small values
   // mixed in so that ties and sign boundaries show up in the minimum.
   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return -1;
         4:       return $signed(DATA_W'($urandom_range(8))) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Commands on an empty queue, size/clear, and the undecoded opcodes.
   task automatic test_empty_queue();
      send_command(OP_DEQUEUE,   $urandom);
      send_command(OP_FRONT,     $urandom);
      send_command(OP_MIN,       $urandom);
      send_command(OP_SIZE,      $urandom);
      send_command(OP_UNUSED_LO, $urandom);
      send_command(OP_UNUSED_HI, $urandom);
      send_command(OP_CLEAR,     $urandom);
   endtask

   // Extreme and zero values through two in-to-out stack moves, with front and
   // min seen from the in-stack only, from both stacks and from the out-stack.
   // A stored zero must not read as an empty slot.
   task automatic test_extremes_and_transfer();
      send_command(OP_ENQUEUE, '0);
      send_command(OP_FRONT,   $urandom);
      send_command(OP_MIN,     $urandom);
      send_command(OP_ENQUEUE, VAL_MAX);
      send_command(OP_ENQUEUE, VAL_MIN);
      send_command(OP_ENQUEUE, -1);
      send_command(OP_MIN,     $urandom);
      send_command(OP_FRONT,   $urandom);
      send_command(OP_DEQUEUE, $urandom);   // moves the in-stack over
      send_command(OP_ENQUEUE, '0);         // lands on an empty in-stack
      send_command(OP_MIN,     $urandom);   // both stacks hold data
      send_command(OP_FRONT,   $urandom);
      send_command(OP_DEQUEUE, $urandom);
      send_command(OP_DEQUEUE, $urandom);
      send_command(OP_DEQUEUE, $urandom);
      send_command(OP_MIN,     $urandom);   // only the in-stack is left
      send_command(OP_DEQUEUE, $urandom);
      send_command(OP_DEQUEUE, $urandom);   // empty again
   endtask

   // Full queue: overflow with everything in the in-stack, a full-depth move,
   // overflow split across both stacks, a few pops, then clear and a dequeue
   // on the emptied queue.
   task automatic test_fill_to_capacity();
      send_command(OP_CLEAR, '0);
      repeat (DEPTH) send_command(OP_ENQUEUE, random_value());
      send_command(OP_ENQUEUE, random_value());
      send_command(OP_SIZE,    '0);
      send_command(OP_MIN,     '0);
      send_command(OP_FRONT,   '0);
      send_command(OP_DEQUEUE, '0);
      send_command(OP_ENQUEUE, random_value());
      send_command(OP_ENQUEUE, random_value());
      send_command(OP_MIN,     '0);
      send_command(OP_FRONT,   '0);
      repeat (4) send_command(OP_DEQUEUE, '0);
      send_command(OP_CLEAR,   '0);
      send_command(OP_DEQUEUE, '0);
      send_command(OP_SIZE,    '0);
   endtask

   // Weighted random traffic. Enqueue bursts build deep in-stacks so later
   // dequeues make long moves; clears keep the depth mostly small. A middle
   // stretch runs with no sender gaps at all.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned pick;
      int unsigned burst;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_enable = !(sent >= 300 && sent < 600);
         pick = $urandom_range(99);
         if (pick < 3) begin
            burst = $urandom_range(120, 20);
            repeat (burst) send_command(OP_ENQUEUE, random_value());
            sent += burst;
         end else begin
            if (pick < 42)
               send_command(OP_ENQUEUE, random_value());
            else if (pick < 71)
               send_command(OP_DEQUEUE, $urandom);
            else if (pick < 79)
               send_command(OP_FRONT, $urandom);
            else if (pick < 87)
               send_command(OP_MIN, $urandom);
            else if (pick < 92)
               send_command(OP_SIZE, $urandom);
            else if (pick < 95)
               send_command(OP_CLEAR, $urandom);
            else if (pick < 97)
               send_command(OP_UNUSED_LO, $urandom);
            else
               send_command(OP_UNUSED_HI, $urandom);
            sent++;
         end
      end
      idle_enable = 1'b1;
   endtask

   // Response checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin : check_responses
      response_type want;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected response: status %0d value %0d count %0d",
                   rsp_status, rsp_result_value, rsp_element_count);
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("result_value: expected %0d, got %0d", want.value, rsp_result_value);
               mismatch_count++;
            end
            if (rsp_element_count !== want.count) begin
               $error("element_count: expected %0d, got %0d",
                      want.count, rsp_element_count);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any request transfer or response strobe counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_SIZE;
      req_push_value = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_extremes_and_transfer();
      test_fill_to_capacity();
      test_random_traffic();

      start = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
